// ----- rtl/rulog_pkg.sv -----
package rulog_pkg;

   // Ring geometry. Pointers index a slot; counts reach the depth itself.
   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = PTR_W + 1;
   localparam int IDX_W      = 64;
   localparam int TERM_W     = 64;

   localparam logic [PTR_W:0]     DEPTH_CODE = (PTR_W + 1)'(RING_DEPTH);
   localparam logic [CNT_W-1:0]   COUNT_FULL = CNT_W'(RING_DEPTH);
   localparam logic [IDX_W-1:0]   FIRST_RESET = IDX_W'(1);

   typedef enum logic [2:0] {
      KIND_APPEND = 3'd0,
      KIND_LOOKUP = 3'd1,
      KIND_DROP   = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_LOAD   = 3'd4
   } rulog_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_GAP  = 2'd1,
      ERR_FULL = 2'd2
   } rulog_error_type;

   typedef enum logic {
      PH_IDLE,
      PH_EXEC
   } rulog_phase_type;

   // One request transaction as captured from the input channel.
   typedef struct packed {
      logic [2:0]        kind;
      logic [IDX_W-1:0]  entry_index;
      logic [TERM_W-1:0] entry_term;
      logic              snap_present;
   } rulog_item_type;

   // Log bookkeeping registers; the terms themselves live in the ring RAM.
   typedef struct packed {
      logic [PTR_W-1:0]  head_pointer;
      logic [CNT_W-1:0]  entry_count;
      logic [IDX_W-1:0]  first_index;
      logic              snapshot_held;
      logic [IDX_W-1:0]  snapshot_index;
      logic [TERM_W-1:0] snapshot_term;
   } rulog_log_type;

   // Compares and addresses worked out in the accept cycle.
   typedef struct packed {
      logic              hit;
      logic              snap_match;
      logic              d_eq_count;
      logic              idx_le_first;
      logic              d_lt_count;
      logic              full;
      logic [CNT_W-1:0]  d_low;
      logic [PTR_W-1:0]  slot;
      logic [PTR_W-1:0]  push_slot;
      logic [IDX_W-1:0]  idx_inc;
   } rulog_plan_type;

   typedef struct packed {
      logic              en;
      logic [PTR_W-1:0]  addr;
      logic [TERM_W-1:0] data;
   } rulog_write_type;

   typedef struct packed {
      logic              ok;
      logic [TERM_W-1:0] term_out;
      logic              last_valid;
      logic [IDX_W-1:0]  last_index;
      logic              unstable_valid;
      logic [IDX_W-1:0]  first_unstable;
      logic [1:0]        error_code;
   } rulog_result_type;

   // Fold a slot sum that is below twice the depth back into the ring.
   function automatic logic [PTR_W-1:0] slot_wrap(input logic [PTR_W:0] sum);
      logic [PTR_W:0] folded;
      folded = (sum >= DEPTH_CODE) ? (sum - DEPTH_CODE) : sum;
      return folded[PTR_W-1:0];
   endfunction

endpackage

// ----- rtl/rulog_req_if.sv -----
interface rulog_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [63:0] entry_index;
   logic [63:0] entry_term;
   logic        snap_present;

   modport source (output valid, kind, entry_index, entry_term, snap_present,
                   input ready);
   modport sink   (input valid, kind, entry_index, entry_term, snap_present,
                   output ready);
endinterface

// ----- rtl/rulog_rsp_if.sv -----
interface rulog_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [63:0] term_out;
   logic        last_valid;
   logic [63:0] last_index;
   logic        unstable_valid;
   logic [63:0] first_unstable;
   logic [1:0]  error_code;

   modport source (output valid, ok, term_out, last_valid, last_index,
                   unstable_valid, first_unstable, error_code,
                   input ready);
   modport sink   (input valid, ok, term_out, last_valid, last_index,
                   unstable_valid, first_unstable, error_code,
                   output ready);
endinterface

// ----- rtl/rulog_ram.sv -----
module rulog_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/rulog_plan.sv -----
module rulog_plan (
   input  rulog_pkg::rulog_item_type item,
   input  rulog_pkg::rulog_log_type  log_state,
   output rulog_pkg::rulog_plan_type plan
);
   import rulog_pkg::*;

   logic [IDX_W-1:0] idx_offset;
   logic [IDX_W-1:0] count_wide;
   logic             below_first;

   // Offset of the requested index from the first held entry.
   assign idx_offset  = item.entry_index - log_state.first_index;
   assign count_wide  = IDX_W'(log_state.entry_count);
   assign below_first = item.entry_index < log_state.first_index;

   // Classify the index against the held range and form both ring addresses.
   always_comb begin
      plan.d_eq_count   = (idx_offset == count_wide);
      plan.idx_le_first = (item.entry_index <= log_state.first_index);
      plan.d_lt_count   = (idx_offset < count_wide);
      plan.hit          = (log_state.entry_count != '0) && !below_first &&
                          (idx_offset < count_wide);
      plan.snap_match   = log_state.snapshot_held &&
                          (log_state.snapshot_index == item.entry_index);
      plan.full         = (log_state.entry_count == COUNT_FULL);
      plan.d_low        = idx_offset[CNT_W-1:0];
      plan.slot         = slot_wrap({1'b0, log_state.head_pointer} +
                                    {1'b0, idx_offset[PTR_W-1:0]});
      plan.push_slot    = slot_wrap({1'b0, log_state.head_pointer} +
                                    log_state.entry_count);
      plan.idx_inc      = item.entry_index + IDX_W'(1);
   end

endmodule

// ----- rtl/rulog_exec.sv -----
module rulog_exec (
   input  rulog_pkg::rulog_item_type   item,
   input  rulog_pkg::rulog_plan_type   plan,
   input  rulog_pkg::rulog_log_type    log_state,
   input  logic [63:0]                 ring_term,
   output rulog_pkg::rulog_log_type    log_next,
   output rulog_pkg::rulog_write_type  wr,
   output rulog_pkg::rulog_result_type result
);
   import rulog_pkg::*;

   logic [CNT_W-1:0] count_less;

   // Carry out the operation using the planned compares and the ring term.
   always_comb begin
      log_next = log_state;
      wr.en    = 1'b0;
      wr.addr  = plan.slot;
      wr.data  = item.entry_term;
      result   = '0;

      case (item.kind)
         KIND_APPEND: begin
            if (plan.d_eq_count) begin
               if (plan.full) begin
                  result.error_code = ERR_FULL;
               end else begin
                  wr.en                = 1'b1;
                  wr.addr              = plan.push_slot;
                  log_next.entry_count = log_state.entry_count + 1'b1;
                  result.ok            = 1'b1;
               end
            end else if (plan.idx_le_first) begin
               // The new entry restarts the log.
               wr.en                 = 1'b1;
               wr.addr               = '0;
               log_next.head_pointer = '0;
               log_next.entry_count  = CNT_W'(1);
               log_next.first_index  = item.entry_index;
               result.ok             = 1'b1;
            end else if (plan.d_lt_count) begin
               // Conflicting tail is cut and the entry takes its place.
               wr.en                = 1'b1;
               log_next.entry_count = plan.d_low + 1'b1;
               result.ok            = 1'b1;
            end else begin
               result.error_code = ERR_GAP;
            end
         end
         KIND_LOOKUP: begin
            if (plan.hit) begin
               result.term_out = ring_term;
               result.ok       = 1'b1;
            end else if (plan.snap_match) begin
               result.term_out = log_state.snapshot_term;
               result.ok       = 1'b1;
            end
         end
         KIND_DROP: begin
            if (plan.hit && (ring_term == item.entry_term)) begin
               log_next.head_pointer = slot_wrap({1'b0, plan.slot} + 1'b1);
               log_next.entry_count  = log_state.entry_count -
                                       (plan.d_low + 1'b1);
               log_next.first_index  = plan.idx_inc;
               result.ok             = 1'b1;
            end
         end
         KIND_CLEAR: begin
            if (plan.snap_match) begin
               log_next.snapshot_held = 1'b0;
               result.ok              = 1'b1;
            end
         end
         KIND_LOAD: begin
            log_next.head_pointer = '0;
            log_next.entry_count  = '0;
            if (item.snap_present) begin
               log_next.snapshot_held  = 1'b1;
               log_next.snapshot_index = item.entry_index;
               log_next.snapshot_term  = item.entry_term;
               log_next.first_index    = plan.idx_inc;
            end else begin
               log_next.snapshot_held  = 1'b0;
               log_next.snapshot_index = '0;
               log_next.snapshot_term  = '0;
               log_next.first_index    = FIRST_RESET;
            end
            result.ok = 1'b1;
         end
         default: begin
         end
      endcase

      // Status fields reflect the log as it stands after the operation.
      count_less = log_next.entry_count - 1'b1;
      if (log_next.entry_count != '0) begin
         result.last_valid = 1'b1;
         result.last_index = log_next.first_index + IDX_W'(count_less);
      end else if (log_next.snapshot_held) begin
         result.last_valid = 1'b1;
         result.last_index = log_next.snapshot_index;
      end else begin
         result.last_valid = 1'b0;
         result.last_index = '0;
      end
      result.unstable_valid = log_next.snapshot_held;
      result.first_unstable = log_next.snapshot_held ?
                              (log_next.snapshot_index + IDX_W'(1)) : '0;
   end

endmodule

// ----- rtl/raft_unstable_log_store_top.sv -----
// Unstable log tail store for a consensus engine.
//
// Requests arrive on the req channel (kind, entry_index, entry_term,
// snap_present) and each produces exactly one response on the rsp channel
// (ok, term_out, last/first-unstable status and an error code). Both
// channels transfer a transaction when valid and ready are high together.
//
// A request is taken in the idle phase, which also issues the ring read at
// the slot the index maps to. The decision phase then decides the operation
// with the read term, writes the ring if needed, updates the log registers
// and loads the response register, waiting while that register is held.
// The response turns valid from the response register after the commit. A
// new request is taken only back in the idle phase, after the previous one
// has committed; this is set by the registered read of the ring memory that
// each operation has to see before it can modify the log.
//
// Reset (synchronous, active high) empties the log, drops the snapshot and
// sets the first index to one; the ring contents are not cleared and need
// no clearing pass. If the receiver stalls, the response is held in its
// register; one more request may be accepted meanwhile and waits in the
// decision phase until the response register frees.
module raft_unstable_log_store_top (
   input logic        clock,
   input logic        reset,
   rulog_req_if.sink   req,
   rulog_rsp_if.source rsp
);
   import rulog_pkg::*;

   rulog_phase_type  phase_ff, phase_in;
   rulog_item_type   item_ff, item_now;
   rulog_plan_type   plan_ff, plan_now;
   rulog_log_type    log_ff, log_next;
   rulog_result_type result_ff, result_now;
   rulog_write_type  wr;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [TERM_W-1:0] ring_term;
   logic             accept;
   logic             rsp_free;
   logic             commit;

   // Input transaction as it stands on the channel.
   assign item_now.kind         = req.kind;
   assign item_now.entry_index  = req.entry_index;
   assign item_now.entry_term   = req.entry_term;
   assign item_now.snap_present = req.snap_present;

   rulog_plan u_plan (
      .item      (item_now),
      .log_state (log_ff),
      .plan      (plan_now)
   );

   rulog_ram #(
      .DEPTH  (RING_DEPTH),
      .WIDTH  (TERM_W),
      .ADDR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr.en && commit),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (accept),
      .rd_addr (plan_now.slot),
      .rd_data (ring_term)
   );

   rulog_exec u_exec (
      .item      (item_ff),
      .plan      (plan_ff),
      .log_state (log_ff),
      .ring_term (ring_term),
      .log_next  (log_next),
      .wr        (wr),
      .result    (result_now)
   );

   // Phase sequencing: accept, then decide once the response slot is free.
   always_comb begin
      req.ready    = (phase_ff == PH_IDLE);
      accept       = req.valid && req.ready;
      rsp_free     = !rsp_valid_ff || rsp.ready;
      commit       = 1'b0;
      phase_in     = phase_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               phase_in = PH_EXEC;
            end
         end
         PH_EXEC: begin
            if (rsp_free) begin
               commit       = 1'b1;
               rsp_valid_in = 1'b1;
               phase_in     = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured request and its plan.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_now;
         plan_ff <= plan_now;
      end
   end

   // Log registers change only on reset or when an operation commits.
   always_ff @(posedge clock) begin
      if (reset) begin
         log_ff.head_pointer   <= '0;
         log_ff.entry_count    <= '0;
         log_ff.first_index    <= FIRST_RESET;
         log_ff.snapshot_held  <= 1'b0;
         log_ff.snapshot_index <= '0;
         log_ff.snapshot_term  <= '0;
      end else if (commit) begin
         log_ff <= log_next;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (commit) begin
         result_ff <= result_now;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.ok             = result_ff.ok;
   assign rsp.term_out       = result_ff.term_out;
   assign rsp.last_valid     = result_ff.last_valid;
   assign rsp.last_index     = result_ff.last_index;
   assign rsp.unstable_valid = result_ff.unstable_valid;
   assign rsp.first_unstable = result_ff.first_unstable;
   assign rsp.error_code     = result_ff.error_code;

   // The held count never exceeds the ring.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      log_ff.entry_count <= COUNT_FULL)
      else $error("entry count exceeds ring depth");

   // A commit always leaves a response waiting.
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed operation produced no response");

   // Without a commit the log registers hold.
   a_log_hold: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(log_ff))
      else $error("log state changed outside a commit");

   // A failed append leaves the log untouched and writes nothing.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (commit && (result_now.error_code != ERR_NONE)) |-> !wr.en ##1 $stable(log_ff))
      else $error("erroring append modified the log");

endmodule
